### sv/nearest_timestamp_table_top_defines.svh
// assertion macros for the nearest timestamp table
// included by the top level; no other dependencies
`ifndef NEAREST_TIMESTAMP_TABLE_TOP_DEFINES_SVH
`define NEAREST_TIMESTAMP_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define NTT_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// next-cycle implication, checked outside reset
`define NTT_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`else

`define NTT_ASSERT_NOW(label, clk, rst, cond, prop)
`define NTT_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

### sv/ntt_pkg.sv
// shared types and constants of the nearest timestamp table
// no dependencies
package ntt_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int STAMP_W     = 31;
   localparam int VALUE_W     = 64;
   localparam int STATUS_W    = 3;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BEFORE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_AFTER  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 3'd4;

   typedef struct packed {
      logic                      op;
      logic [STAMP_W-1:0]        stamp;
      logic signed [VALUE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] found_value;
      logic [STAMP_W-1:0]        found_stamp;
      logic [STATUS_W-1:0]       status;
   } rsp_type;

   typedef struct packed {
      logic [STAMP_W-1:0]        key;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

endpackage

### sv/nearest_timestamp_table_top.sv
// nearest timestamp table: sorted key/value store with nearest-key lookup
// depends on ntt_pkg and nearest_timestamp_table_top_defines.svh
//
// usage
//   req channel (valid/ready): op, stamp, sample. op insert stores the pair in
//   key order or overwrites the value of an equal key; op query looks up the
//   entry nearest stamp, ties going to the later key
//   rsp channel (valid/ready): exactly one transfer per request, in order
//   one item at a time; req_ready is high only while no item is in work
//   timing
//   a binary search over the table takes one memory read per step,
//   ceil(log2(count+1)) steps with count entries stored (at most 11 at 1024)
//   query: an accept state, the search steps, then a resolve state
//   insert of a new key below the last one: as a query, then one entry moved up
//   per cycle and a place step; a new last key, an overwrite or a full
//   drop: as a query
//   reset clears the state, rsp_valid and the entry count; the table contents
//   need no clearing, entries at or above the count are never read
//   a stalled rsp holds its result in the output register; the next item is
//   still accepted and worked on, and only its final step waits for space
`include "nearest_timestamp_table_top_defines.svh"

module nearest_timestamp_table_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ntt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ntt_pkg::rsp_type rsp_payload
);
   import ntt_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_SEARCH  = 5'b00010,
      S_RESOLVE = 5'b00100,
      S_SHIFT   = 5'b01000,
      S_PLACE   = 5'b10000
   } state_type;

   // table memory, one write and one registered read per cycle
   entry_type entry_mem [TABLE_DEPTH];
   entry_type mem_rdata_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [IDX_W-1:0] mem_raddr;
   entry_type        mem_wdata;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   req_type item_ff, item_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [IDX_W-1:0] src_ff, src_in;
   entry_type low_ff, low_in;
   entry_type up_ff, up_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic             req_xfer;
   logic             rsp_free;
   logic             finish;
   rsp_type          result;
   logic [CNT_W-1:0] mid_wide;
   logic [STAMP_W-1:0] dist_low;
   logic [STAMP_W-1:0] dist_up;
   logic             is_full;

   assign req_ready   = (state_ff == S_IDLE);
   assign req_xfer    = req_valid & req_ready;
   assign rsp_free    = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // midpoint of the next search window
   assign mid_wide = lo_in + ((hi_in - lo_in) >> 1);
   assign is_full  = (count_ff == CNT_W'(TABLE_DEPTH));
   assign dist_low = item_ff.stamp - low_ff.key;
   assign dist_up  = up_ff.key - item_ff.stamp;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= entry_mem[mem_raddr];
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      item_in   = item_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      src_in    = src_ff;
      low_in    = low_ff;
      up_in     = up_ff;
      mem_we    = 1'b0;
      mem_waddr = lo_ff[IDX_W-1:0];
      mem_wdata = '{key: item_ff.stamp, value: item_ff.sample};
      mem_raddr = mid_wide[IDX_W-1:0];
      finish    = 1'b0;
      result    = '{found_value: '0, found_stamp: '0, status: STATUS_OK};

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               item_in = req_payload;
               lo_in   = '0;
               hi_in   = count_ff;
               mid_in  = mid_wide[IDX_W-1:0];
               // empty table goes straight to the decision
               state_in = (count_ff == '0) ? S_RESOLVE : S_SEARCH;
            end
         end

         S_SEARCH: begin
            // read data holds the key at mid; keep the neighbor on each side
            if (mem_rdata_ff.key > item_ff.stamp) begin
               hi_in = CNT_W'(mid_ff);
               up_in = mem_rdata_ff;
            end else begin
               lo_in  = CNT_W'(mid_ff) + 1'b1;
               low_in = mem_rdata_ff;
            end
            mid_in = mid_wide[IDX_W-1:0];
            if (!(lo_in < hi_in)) begin
               state_in = S_RESOLVE;
            end
         end

         S_RESOLVE: begin
            if (item_ff.op == OP_QUERY) begin
               finish = rsp_free;
               priority if (count_ff == '0) begin
                  result.status = STATUS_EMPTY;
               end else if (lo_ff == count_ff) begin
                  // exact hit on the last key is ok, anything above is after
                  if (low_ff.key == item_ff.stamp) begin
                     result.found_value = low_ff.value;
                     result.found_stamp = low_ff.key;
                  end else begin
                     result.status = STATUS_AFTER;
                  end
               end else if (lo_ff == '0) begin
                  result.status = STATUS_BEFORE;
               end else if (dist_low < dist_up) begin
                  result.found_value = low_ff.value;
                  result.found_stamp = low_ff.key;
               end else begin
                  // equal distance picks the later key
                  result.found_value = up_ff.value;
                  result.found_stamp = up_ff.key;
               end
            end else begin
               priority if ((lo_ff != '0) && (low_ff.key == item_ff.stamp)) begin
                  // overwrite in place
                  finish    = rsp_free;
                  mem_we    = rsp_free;
                  mem_waddr = IDX_W'(lo_ff - 1'b1);
               end else if (is_full) begin
                  finish        = rsp_free;
                  result.status = STATUS_FULL;
               end else if (lo_ff != count_ff) begin
                  // open a gap: move entries up from the top down
                  src_in    = IDX_W'(count_ff - 1'b1);
                  mem_raddr = IDX_W'(count_ff - 1'b1);
                  state_in  = S_SHIFT;
               end else begin
                  finish   = rsp_free;
                  mem_we   = rsp_free;
                  count_in = rsp_free ? count_ff + 1'b1 : count_ff;
               end
            end
            if (finish) begin
               state_in = S_IDLE;
            end
         end

         S_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = src_ff + 1'b1;
            mem_wdata = mem_rdata_ff;
            if (src_ff == lo_ff[IDX_W-1:0]) begin
               state_in = S_PLACE;
            end else begin
               src_in    = src_ff - 1'b1;
               mem_raddr = src_ff - 1'b1;
            end
         end

         S_PLACE: begin
            if (rsp_free) begin
               finish   = 1'b1;
               mem_we   = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = finish | (rsp_valid_ff & ~rsp_ready);
      rsp_in       = finish ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      src_ff  <= src_in;
      low_ff  <= low_in;
      up_ff   <= up_in;
      rsp_ff  <= rsp_in;
   end

   // search window stays non-empty and inside the stored entries
   `NTT_ASSERT_NOW(a_search_window, clock, reset, state_ff == S_SEARCH,
      (lo_ff < hi_ff) && (hi_ff <= count_ff))
   // the count grows by at most one entry per item and never past the depth
   `NTT_ASSERT_NEXT(a_count_step, clock, reset, 1'b1,
      ((count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + 1'b1))
      && (count_ff <= CNT_W'(TABLE_DEPTH)))
   // no table write while waiting for a request
   `NTT_ASSERT_NOW(a_idle_no_write, clock, reset, state_ff == S_IDLE, !mem_we)
   // an accepted request always leaves idle
   `NTT_ASSERT_NEXT(a_req_starts, clock, reset, req_xfer, state_ff != S_IDLE)

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// self-checking bench for nearest_timestamp_table_top: inserts, overwrites and
// nearest-key queries, checked against a sorted table kept alongside the block
// depends on ntt_pkg and the top level of the block
module tb;
   import ntt_pkg::*;

   // largest key, and the ceiling for random keys so that some headroom stays
   // above the stored keys for the ascending fill of the table
   localparam logic [STAMP_W-1:0] STAMP_MAX       = '1;
   localparam logic [STAMP_W-1:0] RANDOM_KEY_CEIL = 31'h6FFF_FFFF;
   localparam logic [STAMP_W-1:0] CLUSTER_LO      = 31'd900;
   localparam logic [STAMP_W-1:0] CLUSTER_HI      = 31'd6000;
   localparam logic [VALUE_W-1:0] SAMPLE_MAX      = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] SAMPLE_MIN      = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam int                 RANDOM_ITEMS    = 300;
   localparam int                 FULL_ITEMS      = 160;
   localparam int                 TAIL_CYCLES     = 40;
   localparam int                 PRINT_CAP       = 100;

   // how the result side stalls during one stretch of cycles
   typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_type;

   // sorted copy of the table, the results still owed by the block, and counts
   class stamp_table_tracker_type;
      entry_type entries[$];
      rsp_type   pending_results[$];
      int        error_count;
      int        insert_count;
      int        query_count;
      int        tie_count;
      int        status_seen[8];

      // index of the first stored key above stamp, or the table size
      function int upper_index(logic [STAMP_W-1:0] stamp);
         int lo;
         int hi;
         int mid;
         lo = 0;
         hi = entries.size();
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (entries[mid].key > stamp) hi = mid;
            else lo = mid + 1;
         end
         return lo;
      endfunction

      function bit holds_key(logic [STAMP_W-1:0] stamp);
         int up;
         up = upper_index(stamp);
         return (up > 0) && (entries[up-1].key == stamp);
      endfunction

      // applies one item to the table copy and gives the result it must cause
      function rsp_type nearest_result(req_type item);
         rsp_type   res;
         entry_type slot;
         int        up;
         int        pick;
         longint    below_gap;
         longint    above_gap;
         res  = '0;
         pick = -1;
         up   = upper_index(item.stamp);
         if (item.op == OP_INSERT) begin
            insert_count++;
            if (holds_key(item.stamp)) begin
               // equal key: only the value changes
               slot       = entries[up-1];
               slot.value = item.sample;
               entries[up-1] = slot;
               res.status = STATUS_OK;
            end else if (entries.size() >= TABLE_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               slot.key   = item.stamp;
               slot.value = item.sample;
               entries.insert(up, slot);
               res.status = STATUS_OK;
            end
         end else begin
            query_count++;
            if (entries.size() == 0) begin
               res.status = STATUS_EMPTY;
            end else if (up == entries.size()) begin
               // only an exact hit on the last key succeeds past the end
               if (entries[up-1].key == item.stamp) pick = up - 1;
               else res.status = STATUS_AFTER;
            end else if (up == 0) begin
               res.status = STATUS_BEFORE;
            end else begin
               below_gap = longint'(item.stamp) - longint'(entries[up-1].key);
               above_gap = longint'(entries[up].key) - longint'(item.stamp);
               if (below_gap == above_gap) tie_count++;
               pick = (below_gap < above_gap) ? up - 1 : up;
            end
            if (pick >= 0) begin
               res.found_value = entries[pick].value;
               res.found_stamp = entries[pick].key;
               res.status      = STATUS_OK;
            end
         end
         status_seen[res.status]++;
         return res;
      endfunction

      function void note_request(req_type item);
         pending_results.insert(pending_results.size(), nearest_result(item));
      endfunction

      task report_mismatch(string what);
         error_count++;
         if (error_count <= PRINT_CAP) $display("%0t ns: mismatch: %s", $time, what);
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result transfer with none owed (status %0d)",
                                      got.status));
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
         if (got.found_stamp !== want.found_stamp)
            report_mismatch($sformatf("found_stamp %0d, wanted %0d",
                                      got.found_stamp, want.found_stamp));
         if (got.found_value !== want.found_value)
            report_mismatch($sformatf("found_value %0d, wanted %0d",
                                      got.found_value, want.found_value));
      endtask
   endclass

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   stamp_table_tracker_type table_copy = new();

   // transfers left in the current sender burst
   int sender_burst_left = 0;

   nearest_timestamp_table_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic req_type make_item(logic op, logic [STAMP_W-1:0] stamp,
                                         logic [VALUE_W-1:0] sample);
      req_type item;
      item.op     = op;
      item.stamp  = stamp;
      item.sample = sample;
      return item;
   endfunction

   // mostly random values, now and then one of the extremes
   function automatic logic [VALUE_W-1:0] random_sample();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return SAMPLE_MAX;
         3:       return SAMPLE_MIN;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // query stamps aimed at the stored keys: hits, midpoints (ties when the
   // gap is even), neighbors, both outer ends, and plain random stamps
   function automatic logic [STAMP_W-1:0] pick_query_stamp();
      int                 n;
      int                 i;
      logic [STAMP_W-1:0] lo_key;
      logic [STAMP_W-1:0] hi_key;
      logic [STAMP_W-1:0] first_key;
      logic [STAMP_W-1:0] last_key;
      n = table_copy.entries.size();
      if (n == 0) return STAMP_W'($urandom);
      i         = $urandom_range(0, n - 1);
      lo_key    = table_copy.entries[i].key;
      hi_key    = (i + 1 < n) ? table_copy.entries[i+1].key : lo_key;
      first_key = table_copy.entries[0].key;
      last_key  = table_copy.entries[n-1].key;
      case ($urandom_range(0, 8))
         0:       return lo_key;
         1, 2:    return lo_key + ((hi_key - lo_key) >> 1);
         3:       return STAMP_W'(lo_key + ((hi_key - lo_key + 1) >> 1));
         4:       return STAMP_W'(lo_key + 1);
         5:       return STAMP_W'(lo_key - 1);
         6:       return (first_key == 0) ? first_key
                                          : STAMP_W'($urandom_range(0, first_key - 1));
         7:       return (last_key == STAMP_MAX) ? last_key
                                 : STAMP_W'($urandom_range(last_key + 1, STAMP_MAX));
         default: return STAMP_W'($urandom);
      endcase
   endfunction

   // offer one item, wait for its transfer, then maybe close the burst with a gap
   task automatic send_item(input req_type item);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      table_copy.note_request(item);
      if (sender_burst_left > 0) begin
         sender_burst_left--;
      end else begin
         // mostly short bursts, sometimes a long stretch with no idling
         sender_burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 10);
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off the sender until every owed result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (table_copy.pending_results.size() != 0);
   endtask

   // result side: check each transfer, then pick ready for the next edge
   initial begin : result_side
      int          stretch_left;
      rx_mode_type mode;
      stretch_left = 0;
      mode         = RX_ALWAYS;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) table_copy.check_response(rsp_payload);
         if (stretch_left == 0) begin
            mode         = rx_mode_type'($urandom_range(0, 3));
            stretch_left = $urandom_range(20, 200);
         end
         stretch_left--;
         case (mode)
            RX_ALWAYS: rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
            RX_MOSTLY: rsp_ready <= ($urandom_range(0, 9) != 0);
            default:   rsp_ready <= (stretch_left % 16 == 0);
         endcase
      end
   end

   initial begin : stimulus
      int                 n;
      logic [STAMP_W-1:0] key;
      logic [STAMP_W-1:0] next_key;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, single entry, the ends, ties, overwrite
      send_item(make_item(OP_QUERY,  31'd0,     '0));
      send_item(make_item(OP_QUERY,  STAMP_MAX, SAMPLE_MIN));   // sample ignored
      send_item(make_item(OP_INSERT, 31'd1000,  SAMPLE_MAX));
      send_item(make_item(OP_QUERY,  31'd1000,  '0));           // hit on the only key
      send_item(make_item(OP_QUERY,  31'd999,   '0));           // below first key
      send_item(make_item(OP_QUERY,  31'd1001,  '0));           // above last key
      send_item(make_item(OP_INSERT, 31'd2000,  SAMPLE_MIN));
      send_item(make_item(OP_QUERY,  31'd1000,  '1));           // first key, two stored
      send_item(make_item(OP_QUERY,  31'd1500,  '0));           // equal distance
      send_item(make_item(OP_QUERY,  31'd1499,  '0));
      send_item(make_item(OP_QUERY,  31'd2000,  '0));           // hit on the last key
      send_item(make_item(OP_INSERT, 31'd1000,  '1));           // overwrite
      send_item(make_item(OP_QUERY,  31'd1200,  '0));
      send_item(make_item(OP_INSERT, 31'd1500,  '0));           // lands in the middle
      send_item(make_item(OP_QUERY,  31'd1250,  '0));           // equal distance
      send_item(make_item(OP_QUERY,  31'd1750,  '0));           // equal distance
      send_item(make_item(OP_QUERY,  31'd1751,  '0));
      send_item(make_item(OP_QUERY,  31'd0,     '0));
      send_item(make_item(OP_QUERY,  STAMP_MAX, '0));
      send_item(make_item(OP_INSERT, 31'd999,   SAMPLE_MAX));   // new first key
      send_item(make_item(OP_QUERY,  31'd999,   '0));
      wait_for_results();

      // random mix over a growing table, clustered keys so neighbors are close
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 99) < 45) begin
            case ($urandom_range(0, 9))
               0, 1:    key = table_copy.entries[
                                 $urandom_range(0, table_copy.entries.size() - 1)].key;
               2, 3, 4, 5, 6:
                        key = STAMP_W'($urandom_range(CLUSTER_LO, CLUSTER_HI));
               default: key = STAMP_W'($urandom_range(1, RANDOM_KEY_CEIL));
            endcase
            send_item(make_item(OP_INSERT, key, random_sample()));
         end else begin
            send_item(make_item(OP_QUERY, pick_query_stamp(), random_sample()));
         end
      end
      wait_for_results();

      // fill: new keys above the current last one, so each lands at the end
      next_key = table_copy.entries[table_copy.entries.size() - 1].key;
      while (table_copy.entries.size() < TABLE_DEPTH - 2) begin
         if ($urandom_range(0, 11) == 0) begin
            send_item(make_item(OP_QUERY, pick_query_stamp(), random_sample()));
         end else begin
            next_key = STAMP_W'(next_key + $urandom_range(1, 600));
            send_item(make_item(OP_INSERT, next_key, random_sample()));
         end
      end
      // the two extreme keys close the table; key zero moves every entry up
      send_item(make_item(OP_INSERT, 31'd0,     SAMPLE_MIN));
      send_item(make_item(OP_INSERT, STAMP_MAX, SAMPLE_MAX));
      wait_for_results();

      // full table: lookups, overwrites, and new keys that must be dropped
      for (n = 0; n < FULL_ITEMS; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_item(make_item(OP_QUERY, pick_query_stamp(), random_sample()));
            4, 5, 6: begin
               key = table_copy.entries[$urandom_range(0, TABLE_DEPTH - 1)].key;
               send_item(make_item(OP_INSERT, key, random_sample()));
            end
            default: begin
               do key = STAMP_W'($urandom_range(1, STAMP_MAX - 1));
               while (table_copy.holds_key(key));
               send_item(make_item(OP_INSERT, key, random_sample()));
            end
         endcase
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d inserts and %0d queries, %0d at equal distance; %0d entries held",
               table_copy.insert_count, table_copy.query_count, table_copy.tie_count,
               table_copy.entries.size());
      $display("status counts: ok %0d, before %0d, after %0d, empty %0d, full %0d",
               table_copy.status_seen[STATUS_OK], table_copy.status_seen[STATUS_BEFORE],
               table_copy.status_seen[STATUS_AFTER], table_copy.status_seen[STATUS_EMPTY],
               table_copy.status_seen[STATUS_FULL]);
      if (table_copy.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin : watchdog
      #20_000_000;
      $display("timeout with %0d results still owed", table_copy.pending_results.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
